/* rtl/lbp_pkg.sv */
// Package for the streaming 3x3 local binary pattern core.
// Shared widths, register reset values, config register indexes and the
// border mask struct. No dependencies.
package lbp_pkg;

  localparam int CODE_W       = 8;
  localparam int PIX_PORT_W   = 8;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;
  localparam int ROW_W        = 13;
  localparam int OUT_CNT_W    = 22;
  localparam int WIN_N        = 9;
  localparam int WIN_CENTER   = 4;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 11'd4;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd4;
  localparam logic [HEIGHT_REG_W-1:0] MAX_HEIGHT = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // which outer window columns lie inside the frame
  typedef struct packed {
    logic left_ok;
    logic right_ok;
  } border_t;

endpackage

/* rtl/lbp_pattern.sv */
// Combinational 3x3 pattern former: masks the border columns and compares
// the eight neighbours against the centre pixel.
// Depends on lbp_pkg.
module lbp_pattern #(
  parameter int PW = 8
) (
  input  logic [PW-1:0]               win_i [lbp_pkg::WIN_N],
  input  lbp_pkg::border_t            border_i,
  output logic [lbp_pkg::CODE_W-1:0]  code_o
);

  logic [PW-1:0]               e [lbp_pkg::WIN_N];
  logic [lbp_pkg::WIN_N-1:0]   gt;

  always_comb begin
    for (int k = 0; k < lbp_pkg::WIN_N; k++) begin
      e[k] = win_i[k];
    end
    for (int r = 0; r < 3; r++) begin
      if (!border_i.left_ok) begin
        e[r*3] = '0;
      end
      if (!border_i.right_ok) begin
        e[r*3+2] = '0;
      end
    end
    for (int k = 0; k < lbp_pkg::WIN_N; k++) begin
      gt[k] = e[k] > e[lbp_pkg::WIN_CENTER];
    end
  end

  // centre skipped: neighbours after it move down one bit
  assign code_o = {gt[8:5], gt[3:0]};

endmodule

/* rtl/lbp_3x3_stream_core.sv */
// Each accepted pixel beat is registered in the front stage, then in the result
// register; a code leaves W+1 pixel beats after the pixel it is centered on
// (W = image width). Throughput: one beat per cycle while the output is not
// stalled, set by the single read-first port of each of the two line banks.
// Reset clears counters, window and the output valid; the line banks are not
// cleared, as unwritten rows are never read. Config writes restart the frame.
module lbp_3x3_stream_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lbp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lbp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic [lbp_pkg::PIX_PORT_W-1:0]    pixel_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lbp_pkg::CODE_W-1:0]        lbp_code_o,
  output logic                              frame_last_o
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PW  = (PIXEL_BITS < lbp_pkg::PIX_PORT_W) ? PIXEL_BITS
                                                          : lbp_pkg::PIX_PORT_W;
  localparam int FSW = WW + lbp_pkg::HEIGHT_REG_W;

  typedef struct packed {
    logic    par;
    logic    up_ok;
    logic    lo_ok;
    logic    emit;
    logic    last;
    lbp_pkg::border_t border;
  } s1_ctrl_t;

  function automatic logic [WW-1:0] clamp_w(logic [lbp_pkg::WIDTH_REG_W-1:0] v);
    if (v == '0) begin
      return WW'(1);
    end else if (32'(v) > MAX_WIDTH) begin
      return WW'(MAX_WIDTH);
    end else begin
      return WW'(v);
    end
  endfunction

  function automatic logic [lbp_pkg::HEIGHT_REG_W-1:0] clamp_h(
    logic [lbp_pkg::HEIGHT_REG_W-1:0] v
  );
    if (v == '0) begin
      return lbp_pkg::HEIGHT_REG_W'(1);
    end else if (v > lbp_pkg::MAX_HEIGHT) begin
      return lbp_pkg::MAX_HEIGHT;
    end else begin
      return v;
    end
  endfunction

  // config registers and derived frame size
  logic [lbp_pkg::WIDTH_REG_W-1:0]  width_q, width_d;
  logic [lbp_pkg::HEIGHT_REG_W-1:0] height_q, height_d;
  logic [FSW-1:0]                   frame_size_q, frame_size_d;
  logic [WW-1:0]                    eff_w;
  logic [lbp_pkg::HEIGHT_REG_W-1:0] eff_h;

  // position counters
  logic [WW-1:0]                    col_q, col_d, col_inc;
  logic [lbp_pkg::ROW_W-1:0]        row_q, row_d;
  logic [lbp_pkg::OUT_CNT_W-1:0]    out_cnt_q, out_cnt_d;

  // front stage
  logic                             en, in_acc;
  logic [AW-1:0]                    addr;
  logic [PW-1:0]                    a_x;
  logic                             a_col_zero, a_emit, a_last, a_row_end;
  s1_ctrl_t                         a_ctrl;

  logic [PW-1:0]                    bank0_mem [MAX_WIDTH];
  logic [PW-1:0]                    bank1_mem [MAX_WIDTH];
  logic [PW-1:0]                    rd0_q, rd1_q;
  logic [PW-1:0]                    s1_x_q;
  s1_ctrl_t                         s1_ctrl_q;
  logic                             s1_valid_q;

  // window stage
  logic [PW-1:0]                    rcol [3];
  logic [PW-1:0]                    mid_q [3];
  logic [PW-1:0]                    rgt_q [3];
  logic [PW-1:0]                    win [lbp_pkg::WIN_N];
  logic [lbp_pkg::CODE_W-1:0]       code;

  logic                             out_valid_q;
  logic [lbp_pkg::CODE_W-1:0]       code_q;
  logic                             last_q;

  assign eff_w = clamp_w(width_q);
  assign eff_h = clamp_h(height_q);

  // whole pipe moves when the result register can take a beat
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;
  assign in_acc     = in_valid_i && en;

  assign addr       = col_q[AW-1:0];
  assign col_inc    = col_q + WW'(1);
  assign a_row_end  = (col_inc == eff_w);
  assign a_col_zero = (col_q == '0);
  assign a_x        = (action_i || row_q >= eff_h) ? '0 : pixel_i[PW-1:0];
  assign a_emit     = a_col_zero ? (row_q >= lbp_pkg::ROW_W'(2)) : (row_q != '0);
  assign a_last     = a_emit && ((32'(out_cnt_q) + 32'd1) >= 32'(frame_size_q));

  always_comb begin
    a_ctrl.par             = row_q[0];
    a_ctrl.up_ok           = row_q >= lbp_pkg::ROW_W'(2);
    a_ctrl.lo_ok           = row_q != '0;
    a_ctrl.emit            = a_emit;
    a_ctrl.last            = a_last;
    a_ctrl.border.left_ok  = a_col_zero ? (eff_w >= WW'(2)) : (col_q >= WW'(2));
    a_ctrl.border.right_ok = !a_col_zero;
  end

  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    col_d     = col_q;
    row_d     = row_q;
    out_cnt_d = out_cnt_q;
    if (cfg_we_i) begin
      unique case (lbp_pkg::cfg_reg_e'(cfg_index_i))
        lbp_pkg::REG_IMAGE_WIDTH: begin
          width_d = cfg_data_i[lbp_pkg::WIDTH_REG_W-1:0];
        end
        lbp_pkg::REG_IMAGE_HEIGHT: begin
          height_d = cfg_data_i[lbp_pkg::HEIGHT_REG_W-1:0];
        end
        default: begin
          width_d = width_q;
        end
      endcase
      col_d     = '0;
      row_d     = '0;
      out_cnt_d = '0;
    end else if (in_acc) begin
      if (a_last) begin
        col_d     = '0;
        row_d     = '0;
        out_cnt_d = '0;
      end else begin
        col_d = a_row_end ? '0 : col_inc;
        if (a_row_end && row_q != '1) begin
          row_d = row_q + lbp_pkg::ROW_W'(1);
        end
        if (a_emit) begin
          out_cnt_d = out_cnt_q + lbp_pkg::OUT_CNT_W'(1);
        end
      end
    end
    frame_size_d = FSW'(clamp_w(width_d)) * FSW'(clamp_h(height_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= lbp_pkg::WIDTH_RST;
      height_q     <= lbp_pkg::HEIGHT_RST;
      frame_size_q <= FSW'(clamp_w(lbp_pkg::WIDTH_RST)) *
                      FSW'(clamp_h(lbp_pkg::HEIGHT_RST));
      col_q        <= '0;
      row_q        <= '0;
      out_cnt_q    <= '0;
    end else begin
      width_q      <= width_d;
      height_q     <= height_d;
      frame_size_q <= frame_size_d;
      col_q        <= col_d;
      row_q        <= row_d;
      out_cnt_q    <= out_cnt_d;
    end
  end

  // Two line banks by row parity: bank[r%2] holds the row two above on read
  // (read-first), and takes the current row; the other bank holds the row above.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd0_q <= bank0_mem[addr];
      if (!row_q[0]) begin
        bank0_mem[addr] <= a_x;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd1_q <= bank1_mem[addr];
      if (row_q[0]) begin
        bank1_mem[addr] <= a_x;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_x_q    <= a_x;
      s1_ctrl_q <= a_ctrl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // new right column of the window
  always_comb begin
    rcol[0] = s1_ctrl_q.up_ok ? (s1_ctrl_q.par ? rd1_q : rd0_q) : '0;
    rcol[1] = s1_ctrl_q.lo_ok ? (s1_ctrl_q.par ? rd0_q : rd1_q) : '0;
    rcol[2] = s1_x_q;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = mid_q[r];
      win[r*3+1] = rgt_q[r];
      win[r*3+2] = rcol[r];
    end
  end

  lbp_pattern #(
    .PW(PW)
  ) u_pattern (
    .win_i   (win),
    .border_i(s1_ctrl_q.border),
    .code_o  (code)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        mid_q[r] <= '0;
        rgt_q[r] <= '0;
      end
    end else if (en && s1_valid_q) begin
      for (int r = 0; r < 3; r++) begin
        mid_q[r] <= rgt_q[r];
        rgt_q[r] <= rcol[r];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s1_valid_q && s1_ctrl_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s1_valid_q && s1_ctrl_q.emit) begin
      code_q <= code;
      last_q <= s1_ctrl_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign lbp_code_o   = code_q;
  assign frame_last_o = last_q;

  // column pointer never leaves the active row
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < eff_w)
    else $error("column pointer beyond image width");

  // a result only appears behind a front-stage beat
  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result valid without a front-stage beat");

  // the frame's final pixel restarts position and code count
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !cfg_we_i && a_last) |=>
      (col_q == '0 && row_q == '0 && out_cnt_q == '0))
    else $error("frame did not restart after its final pixel");

  // an empty result register never holds off the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled while result register is empty");

endmodule
